[rtl/core/sprf16_pkg.sv]
// Shared types, constants and helper function of the Fletcher-16 sync packet receiver.
package sprf16_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PosW        = 9;
  localparam int unsigned MaxPayloadDef = 255;

  localparam logic [PosW-1:0] PosSyncFirst  = PosW'(0);
  localparam logic [PosW-1:0] PosSyncSecond = PosW'(1);
  localparam logic [PosW-1:0] PosType       = PosW'(2);
  localparam logic [PosW-1:0] PosLength     = PosW'(3);
  localparam logic [PosW-1:0] PosPayload    = PosW'(4);

  localparam logic [ByteW-1:0] SumInit = 8'hFF;

  typedef enum logic {
    CfgSyncFirst  = 1'b0,
    CfgSyncSecond = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_index;
    logic [ByteW-1:0] payload_byte;
    logic             frame_done;
    logic             frame_ok;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] frame_length;
  } result_t;

  // Adds two bytes modulo 255 with end-around carry.
  function automatic logic [ByteW-1:0] fold_add(input logic [ByteW-1:0] a,
                                                input logic [ByteW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, 8'hFF}) begin
      s = s - {1'b0, 8'hFF};
    end
    return s[ByteW-1:0];
  endfunction

endpackage

[rtl/core/sprf16_if.sv]
// Valid/ready channel interfaces for received bytes and result items.
interface sprf16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sprf16_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_index;
  logic [7:0] payload_byte;
  logic       frame_done;
  logic       frame_ok;
  logic [7:0] frame_type;
  logic [7:0] frame_length;

  modport source (output valid, output payload_valid, output payload_index,
                  output payload_byte, output frame_done, output frame_ok,
                  output frame_type, output frame_length, input ready);
  modport sink   (input valid, input payload_valid, input payload_index,
                  input payload_byte, input frame_done, input frame_ok,
                  input frame_type, input frame_length, output ready);
endinterface

[rtl/core/sprf16_frame.sv]
// Frame tracker: sync hunt, header capture, Fletcher-16 sums and per-byte result.
module sprf16_frame import sprf16_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_idx_i,
  input  logic [ByteW-1:0] cfg_data_i,
  output result_t          res_o
);

  logic [ByteW-1:0] sync_first_q, sync_second_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] sum1_q, sum1_d;
  logic [ByteW-1:0] sum2_q, sum2_d;
  logic [ByteW-1:0] chk_hi_q, chk_hi_d;

  logic [ByteW-1:0] add1_base, add2_base, add1, add2;
  logic             do_add;
  logic [PosW-1:0]  frame_end;

  assign frame_end = {1'b0, len_q} + PosPayload;
  assign add1      = fold_add(add1_base, rx_byte_i);
  assign add2      = fold_add(add2_base, add1);

  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    type_d    = type_q;
    chk_hi_d  = chk_hi_q;
    do_add    = 1'b0;
    add1_base = sum1_q;
    add2_base = sum2_q;
    res_o     = '0;
    if (pos_q == PosSyncFirst) begin
      len_d = '0;
      if (rx_byte_i == sync_first_q) begin
        do_add = 1'b1; add1_base = SumInit; add2_base = SumInit;
        pos_d = PosSyncSecond;
      end
    end else if (pos_q == PosSyncSecond) begin
      if (rx_byte_i == sync_second_q) begin
        do_add = 1'b1;
        pos_d  = PosType;
      end else if (rx_byte_i == sync_first_q) begin
        do_add = 1'b1; add1_base = SumInit; add2_base = SumInit;
        pos_d = PosSyncSecond;
      end else begin
        pos_d = PosSyncFirst;
      end
    end else if (pos_q == PosType) begin
      type_d = rx_byte_i;
      do_add = 1'b1;
      pos_d  = PosLength;
    end else if (pos_q == PosLength) begin
      len_d = rx_byte_i;
      if ({1'b0, rx_byte_i} > PosW'(MaxPayload)) begin
        pos_d = PosSyncFirst;
      end else begin
        do_add = 1'b1;
        pos_d  = PosPayload;
      end
    end else if (pos_q < frame_end) begin
      res_o.payload_valid = 1'b1;
      res_o.payload_index = ByteW'(pos_q - PosPayload);
      res_o.payload_byte  = rx_byte_i;
      do_add = 1'b1;
      pos_d  = pos_q + PosW'(1);
    end else if (pos_q == frame_end) begin
      chk_hi_d = rx_byte_i;
      pos_d    = pos_q + PosW'(1);
    end else begin
      res_o.frame_done = 1'b1;
      res_o.frame_ok   = (chk_hi_q == sum2_q) && (rx_byte_i == sum1_q);
      pos_d = PosSyncFirst;
    end
    sum1_d = do_add ? add1 : sum1_q;
    sum2_d = do_add ? add2 : sum2_q;
    res_o.frame_type   = type_d;
    res_o.frame_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_second_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSyncFirst:  sync_first_q  <= cfg_data_i;
        CfgSyncSecond: sync_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosSyncFirst;
      len_q    <= '0;
      type_q   <= '0;
      sum1_q   <= SumInit;
      sum2_q   <= SumInit;
      chk_hi_q <= '0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      type_q   <= type_d;
      sum1_q   <= sum1_d;
      sum2_q   <= sum2_d;
      chk_hi_q <= chk_hi_d;
    end
  end

endmodule

[rtl/core/sync_packet_receiver_fletcher16_top.sv]
// Top level of the sync packet receiver with Fletcher-16 check and output skid stage.
//
// The block takes one received byte per item on in_i and returns exactly one
// result item per byte on out_o. It hunts for the two configured sync bytes,
// captures type and length, echoes payload bytes with their offset and flags
// the end of each frame together with the checksum verdict.
// Sync values are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must do so only while idle; the block itself does not enforce it. Results are
// formed combinationally; one item per cycle is taken while skid_valid_q is low.
// A two-entry output stage of a result register and a skid register lets
// a new item be taken while a result is still waiting on a stalled receiver.
// When both entries are full, in_i.ready is low until the receiver takes one.
// Reset clears the sync values to zero, both sums to 0xFF, and returns the
// block to hunting with no result pending.
module sync_packet_receiver_fletcher16_top import sprf16_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sprf16_in_if.sink         in_i,
  sprf16_out_if.source      out_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ByteW-1:0]  cfg_data_i
);

  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    accept;

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && !skid_valid_q;

  sprf16_frame #(.MaxPayload(MaxPayload)) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (in_i.rx_byte),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_valid = out_q.payload_valid;
  assign out_o.payload_index = out_q.payload_index;
  assign out_o.payload_byte  = out_q.payload_byte;
  assign out_o.frame_done    = out_q.frame_done;
  assign out_o.frame_ok      = out_q.frame_ok;
  assign out_o.frame_type    = out_q.frame_type;
  assign out_o.frame_length  = out_q.frame_length;

endmodule
